FILE: rtl/lcli_pkg.sv
// Shared constants for the lookahead circle-line intersection block.
`timescale 1ns / 1ps

package lcli_pkg;

	localparam int COORD_WIDTH_DEF = 24;
	localparam int FRAC_BITS_DEF   = 8;

	localparam int            RADIUS_W    = 16;
	localparam int            RADIUS_FRAC = 8;
	localparam logic [15:0]   RADIUS_RST  = 16'd3072;

	// register index of the lookahead radius
	localparam logic          REG_LOOKAHEAD = 1'b0;

	// extra fraction bits of the segment length used for the unit direction
	localparam int            DIR_FRAC = 30;

endpackage

FILE: rtl/lookahead_circle_line_intersect_top.sv
// Pipelined pure-pursuit lookahead point: circle-line intersection in fixed point.
`timescale 1ns / 1ps

//  channel   | signals                                   | transfer when
//  ----------+-------------------------------------------+-------------------------------
//  input     | in_valid, in_stall, seg_*, robot_*        | in_valid & !in_stall
//  output    | out_valid, out_stall, target_*, valid_res | out_valid & !out_stall
//  config    | psel, penable, pwrite, paddr, pwdata      | psel & penable & pwrite & pready
//
//  One transfer per cycle sustained while out_stall stays low. Latency is set by the widths
//  through the bit-per-stage dividers and square roots.
//  in_stall rises only when the output register and its skid stage both hold a result;
//  the whole pipeline then freezes, and nothing is lost or repeated.
//  Reset clears the valid bits, the skid and the radius (12.0 inches); no clearing pass.

module lookahead_circle_line_intersect_top #(
	parameter int COORD_WIDTH = lcli_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = lcli_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// config port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	// input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_WIDTH-1:0] seg_start_x,
	input  logic signed [COORD_WIDTH-1:0] seg_start_y,
	input  logic signed [COORD_WIDTH-1:0] seg_end_x,
	input  logic signed [COORD_WIDTH-1:0] seg_end_y,
	input  logic signed [COORD_WIDTH-1:0] robot_x,
	input  logic signed [COORD_WIDTH-1:0] robot_y,
	// output channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [COORD_WIDTH-1:0] target_x,
	output logic signed [COORD_WIDTH-1:0] target_y,
	output logic                          valid_res
);

	localparam int CW   = COORD_WIDTH;
	localparam int SDW  = CW + 1;            // signed difference
	localparam int MW   = CW;                // magnitude of a difference
	localparam int PW   = 2 * SDW;           // signed product
	localparam int LW   = 2 * CW + 1;        // squared length
	localparam int DMW  = 2 * CW + 1;        // |cross product|
	localparam int DLO  = CW + 1;            // low split of |cross product|
	localparam int DHI  = DMW - DLO;
	localparam int NFW  = DMW + MW + 1;      // foot point numerator
	localparam int QFW  = CW + 2;            // foot point magnitude
	localparam int DFW  = NFW + 1;
	localparam int RCW  = FRAC_BITS + lcli_pkg::RADIUS_FRAC;
	localparam int SHL  = (FRAC_BITS >= lcli_pkg::RADIUS_FRAC) ?
		FRAC_BITS - lcli_pkg::RADIUS_FRAC : 0;
	localparam int SHR  = (FRAC_BITS >= lcli_pkg::RADIUS_FRAC) ?
		0 : lcli_pkg::RADIUS_FRAC - FRAC_BITS;
	localparam int F2W  = 2 * QFW + 1;
	localparam int S2W  = (2 * RCW > F2W) ? 2 * RCW : F2W;
	localparam int SQW  = (S2W + 1) / 2;     // floor root bits
	localparam int SW   = SQW + 1;           // rounded root
	localparam int SQT  = 2 * SQW + 1;
	localparam int DRV  = LW + 2 * lcli_pkg::DIR_FRAC;
	localparam int DRQ  = (DRV + 1) / 2;
	localparam int DRSW = DRQ + 1;
	localparam int DQT  = 2 * DRQ + 1;
	localparam int PSW  = SW + MW;
	localparam int NOW  = ((PSW + lcli_pkg::DIR_FRAC > DRSW) ?
		PSW + lcli_pkg::DIR_FRAC : DRSW) + 1;
	localparam int QOW  = SW + 1;
	localparam int DOW  = NOW + 2;
	localparam int FSW  = QFW + 1;
	localparam int OSW  = QOW + 1;
	localparam int TW   = ((CW > FSW) ? ((CW > OSW) ? CW : OSW) :
		((FSW > OSW) ? FSW : OSW)) + 2;

	// stage map
	localparam int ST_MUL = 2;
	localparam int ST_SUM = 3;
	localparam int ST_ABS = 4;
	localparam int ST_PP  = 5;
	localparam int ST_NUM = 6;
	localparam int ST_FD0 = 7;
	localparam int ST_FSQ = ST_FD0 + QFW;
	localparam int ST_F2  = ST_FSQ + 1;
	localparam int ST_S2  = ST_F2 + 1;
	localparam int ST_SQ0 = ST_S2 + 1;
	localparam int ST_SR  = ST_SQ0 + SQW;
	localparam int ST_DQ0 = ST_SR + 1;
	localparam int ST_DR  = ST_DQ0 + DRQ;
	localparam int ST_OP  = ST_DR + 1;
	localparam int ST_ON  = ST_OP + 1;
	localparam int ST_OD0 = ST_ON + 1;
	localparam int ST_E1  = ST_OD0 + QOW;
	localparam int ST_E2  = ST_E1 + 1;
	localparam int NST    = ST_E2 + 1;

	localparam logic signed [TW-1:0] SAT_HI = {{(TW - CW + 1){1'b0}}, {(CW - 1){1'b1}}};
	localparam logic signed [TW-1:0] SAT_LO = {{(TW - CW + 1){1'b1}}, {(CW - 1){1'b0}}};

	typedef struct packed {
		logic signed [CW-1:0]  rx;
		logic signed [CW-1:0]  ry;
		logic signed [SDW-1:0] ax;
		logic signed [SDW-1:0] ay;
		logic signed [SDW-1:0] bx;
		logic signed [SDW-1:0] by;
		logic signed [SDW-1:0] dx;
		logic signed [SDW-1:0] dy;
		logic [MW-1:0]         mdx;
		logic [MW-1:0]         mdy;
		logic signed [PW-1:0]  p_ab;
		logic signed [PW-1:0]  p_ba;
		logic signed [PW-1:0]  p_bdx;
		logic signed [PW-1:0]  p_bdy;
		logic signed [PW-1:0]  p_dxx;
		logic signed [PW-1:0]  p_dyy;
		logic signed [PW:0]    dval;
		logic                  dneg;
		logic                  dotneg;
		logic                  dotz;
		logic [LW-1:0]         l2;
		logic                  l2z;
		logic [DMW-1:0]        dmag;
		logic [DLO+MW-1:0]     pp_xl;
		logic [DHI+MW-1:0]     pp_xh;
		logic [DLO+MW-1:0]     pp_yl;
		logic [DHI+MW-1:0]     pp_yh;
		logic [NFW-1:0]        remx;
		logic [NFW-1:0]        remy;
		logic [QFW-1:0]        qx;
		logic [QFW-1:0]        qy;
		logic [2*QFW-1:0]      fx2;
		logic [2*QFW-1:0]      fy2;
		logic [2*RCW-1:0]      r2;
		logic [F2W-1:0]        f2;
		logic [S2W-1:0]        srem;
		logic [SW-1:0]         sroot;
		logic                  ok;
		logic [DRV-1:0]        drem;
		logic [DRSW-1:0]       droot;
		logic [PSW-1:0]        psx;
		logic [PSW-1:0]        psy;
		logic [NOW-1:0]        orx;
		logic [NOW-1:0]        ory;
		logic [QOW-1:0]        oqx;
		logic [QOW-1:0]        oqy;
		logic signed [FSW-1:0] fxs;
		logic signed [FSW-1:0] fys;
		logic signed [OSW-1:0] oxs;
		logic signed [OSW-1:0] oys;
		logic signed [TW-1:0]  tx;
		logic signed [TW-1:0]  ty;
		logic signed [CW-1:0]  tgx;
		logic signed [CW-1:0]  tgy;
	} ctx_t;

	// ------------------------------------------------------------------
	// one pipeline stage: each index does only its own slice of the work
	// ------------------------------------------------------------------
	function automatic ctx_t step(input int i, input ctx_t c, input logic [15:0] rad);
		ctx_t                n;
		int                  j;
		logic [DFW-1:0]      tf;
		logic [SQT-1:0]      ts;
		logic [DQT-1:0]      td;
		logic [DOW-1:0]      tq;
		logic [RCW-1:0]      rc;
		logic signed [PW:0]  dot;
		logic                sx_neg;
		logic                sy_neg;
		n  = c;
		j  = 0;
		tf = '0;
		ts = '0;
		td = '0;
		tq = '0;
		rc = '0;
		if (i == ST_MUL) begin
			n.p_ab  = PW'(c.ax) * PW'(c.by);
			n.p_ba  = PW'(c.bx) * PW'(c.ay);
			n.p_bdx = PW'(c.bx) * PW'(c.dx);
			n.p_bdy = PW'(c.by) * PW'(c.dy);
			n.p_dxx = PW'(c.dx) * PW'(c.dx);
			n.p_dyy = PW'(c.dy) * PW'(c.dy);
			n.mdx   = c.dx[SDW-1] ? MW'(-c.dx) : MW'(c.dx);
			n.mdy   = c.dy[SDW-1] ? MW'(-c.dy) : MW'(c.dy);
		end else if (i == ST_SUM) begin
			n.dval   = (PW + 1)'(c.p_ab) - (PW + 1)'(c.p_ba);
			dot      = (PW + 1)'(c.p_bdx) + (PW + 1)'(c.p_bdy);
			n.dotneg = dot[PW];
			n.dotz   = (dot == '0);
			n.l2     = LW'(c.p_dxx) + LW'(c.p_dyy);
		end else if (i == ST_ABS) begin
			n.dneg = c.dval[PW];
			n.dmag = c.dval[PW] ? DMW'(-c.dval) : DMW'(c.dval);
			n.l2z  = (c.l2 == '0);
		end else if (i == ST_PP) begin
			n.pp_xl = (DLO + MW)'(c.dmag[DLO-1:0]) * (DLO + MW)'(c.mdy);
			n.pp_xh = (DHI + MW)'(c.dmag[DMW-1:DLO]) * (DHI + MW)'(c.mdy);
			n.pp_yl = (DLO + MW)'(c.dmag[DLO-1:0]) * (DLO + MW)'(c.mdx);
			n.pp_yh = (DHI + MW)'(c.dmag[DMW-1:DLO]) * (DHI + MW)'(c.mdx);
		end else if (i == ST_NUM) begin
			// rounded division: add half the divisor
			n.remx = (NFW'(c.pp_xh) << DLO) + NFW'(c.pp_xl) + NFW'(c.l2 >> 1);
			n.remy = (NFW'(c.pp_yh) << DLO) + NFW'(c.pp_yl) + NFW'(c.l2 >> 1);
			n.qx   = '0;
			n.qy   = '0;
		end else if (i >= ST_FD0 && i < ST_FSQ) begin
			j  = QFW - 1 - (i - ST_FD0);
			tf = DFW'(c.l2) << j;
			if (DFW'(c.remx) >= tf) begin
				n.remx = NFW'(DFW'(c.remx) - tf);
				n.qx   = c.qx | (QFW'(1) << j);
			end
			if (DFW'(c.remy) >= tf) begin
				n.remy = NFW'(DFW'(c.remy) - tf);
				n.qy   = c.qy | (QFW'(1) << j);
			end
		end else if (i == ST_FSQ) begin
			if (FRAC_BITS >= lcli_pkg::RADIUS_FRAC) begin
				rc = RCW'(rad) << SHL;
			end else begin
				rc = RCW'(rad >> SHR);
			end
			n.fx2 = (2 * QFW)'(c.qx) * (2 * QFW)'(c.qx);
			n.fy2 = (2 * QFW)'(c.qy) * (2 * QFW)'(c.qy);
			n.r2  = (2 * RCW)'(rc) * (2 * RCW)'(rc);
		end else if (i == ST_F2) begin
			n.f2 = F2W'(c.fx2) + F2W'(c.fy2);
		end else if (i == ST_S2) begin
			// absolute discriminant
			n.srem  = (S2W'(c.r2) >= S2W'(c.f2)) ? S2W'(c.r2) - S2W'(c.f2) :
				S2W'(c.f2) - S2W'(c.r2);
			n.sroot = '0;
			n.drem  = DRV'(c.l2) << (2 * lcli_pkg::DIR_FRAC);
			n.droot = '0;
		end else if (i >= ST_SQ0 && i < ST_SR) begin
			j  = SQW - 1 - (i - ST_SQ0);
			ts = (SQT'(c.sroot) << (j + 1)) + (SQT'(1) << (2 * j));
			if (SQT'(c.srem) >= ts) begin
				n.srem  = S2W'(SQT'(c.srem) - ts);
				n.sroot = c.sroot | (SW'(1) << j);
			end
		end else if (i == ST_SR) begin
			if (S2W'(c.sroot) < c.srem) begin
				n.sroot = c.sroot + SW'(1);
			end
			// rounded root is zero only when the discriminant is
			n.ok = !c.l2z && !c.dotz && ((c.sroot != '0) || (c.srem != '0));
		end else if (i >= ST_DQ0 && i < ST_DR) begin
			j  = DRQ - 1 - (i - ST_DQ0);
			td = (DQT'(c.droot) << (j + 1)) + (DQT'(1) << (2 * j));
			if (DQT'(c.drem) >= td) begin
				n.drem  = DRV'(DQT'(c.drem) - td);
				n.droot = c.droot | (DRSW'(1) << j);
			end
		end else if (i == ST_DR) begin
			if (DRV'(c.droot) < c.drem) begin
				n.droot = c.droot + DRSW'(1);
			end
		end else if (i == ST_OP) begin
			n.psx = PSW'(c.sroot) * PSW'(c.mdx);
			n.psy = PSW'(c.sroot) * PSW'(c.mdy);
		end else if (i == ST_ON) begin
			n.orx = (NOW'(c.psx) << lcli_pkg::DIR_FRAC) + NOW'(c.droot >> 1);
			n.ory = (NOW'(c.psy) << lcli_pkg::DIR_FRAC) + NOW'(c.droot >> 1);
			n.oqx = '0;
			n.oqy = '0;
		end else if (i >= ST_OD0 && i < ST_E1) begin
			j  = QOW - 1 - (i - ST_OD0);
			tq = DOW'(c.droot) << j;
			if (DOW'(c.orx) >= tq) begin
				n.orx = NOW'(DOW'(c.orx) - tq);
				n.oqx = c.oqx | (QOW'(1) << j);
			end
			if (DOW'(c.ory) >= tq) begin
				n.ory = NOW'(DOW'(c.ory) - tq);
				n.oqy = c.oqy | (QOW'(1) << j);
			end
		end else if (i == ST_E1) begin
			n.fxs  = (c.dneg != c.dy[SDW-1]) ? -$signed({1'b0, c.qx}) : $signed({1'b0, c.qx});
			n.fys  = (c.dneg == c.dx[SDW-1]) ? -$signed({1'b0, c.qy}) : $signed({1'b0, c.qy});
			// pick the point nearer the segment end
			sx_neg = c.dx[SDW-1] ^ c.dotneg;
			sy_neg = c.dy[SDW-1] ^ c.dotneg;
			n.oxs  = sx_neg ? -$signed({1'b0, c.oqx}) : $signed({1'b0, c.oqx});
			n.oys  = sy_neg ? -$signed({1'b0, c.oqy}) : $signed({1'b0, c.oqy});
		end else if (i == ST_E2) begin
			n.tx = TW'(c.rx) + TW'(c.fxs) + TW'(c.oxs);
			n.ty = TW'(c.ry) + TW'(c.fys) + TW'(c.oys);
		end else if (i == NST) begin
			if (!c.ok) begin
				n.tgx = '0;
				n.tgy = '0;
			end else begin
				n.tgx = (c.tx > SAT_HI) ? CW'(SAT_HI) : (c.tx < SAT_LO) ? CW'(SAT_LO) : CW'(c.tx);
				n.tgy = (c.ty > SAT_HI) ? CW'(SAT_HI) : (c.ty < SAT_LO) ? CW'(SAT_LO) : CW'(c.ty);
			end
		end
		return n;
	endfunction

	// ------------------------------------------------------------------
	// config register
	// ------------------------------------------------------------------
	logic [15:0] radius_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == lcli_pkg::REG_LOOKAHEAD) ? {16'b0, radius_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= lcli_pkg::RADIUS_RST;
		end else if (cfg_wr && (paddr[2] == lcli_pkg::REG_LOOKAHEAD)) begin
			radius_q <= pwdata[15:0];
		end
	end

	// ------------------------------------------------------------------
	// pipeline; every stage moves together while the skid has room
	// ------------------------------------------------------------------
	logic sk_full_q;
	logic adv;
	ctx_t in_ctx;
	ctx_t ctx_s [1:NST];
	logic vld_s [1:NST];

	assign adv      = !sk_full_q;
	assign in_stall = sk_full_q;

	// first stage: differences relative to the robot and the segment direction
	always_comb begin
		in_ctx    = '0;
		in_ctx.rx = robot_x;
		in_ctx.ry = robot_y;
		in_ctx.ax = SDW'(seg_start_x) - SDW'(robot_x);
		in_ctx.ay = SDW'(seg_start_y) - SDW'(robot_y);
		in_ctx.bx = SDW'(seg_end_x) - SDW'(robot_x);
		in_ctx.by = SDW'(seg_end_y) - SDW'(robot_y);
		in_ctx.dx = SDW'(seg_end_x) - SDW'(seg_start_x);
		in_ctx.dy = SDW'(seg_end_y) - SDW'(seg_start_y);
	end

	for (genvar g = 1; g <= NST; g++) begin : g_stage
		ctx_t nxt;
		if (g == 1) begin : g_first
			assign nxt = in_ctx;
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[g] <= 1'b0;
				end else if (adv) begin
					vld_s[g] <= in_valid;
				end
			end
		end else begin : g_rest
			always_comb nxt = step(g, ctx_s[g-1], radius_q);
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[g] <= 1'b0;
				end else if (adv) begin
					vld_s[g] <= vld_s[g-1];
				end
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				ctx_s[g] <= nxt;
			end
		end
	end

	// ------------------------------------------------------------------
	// output register with skid stage
	// ------------------------------------------------------------------
	logic                  out_vld_q;
	logic signed [CW-1:0]  out_x_q;
	logic signed [CW-1:0]  out_y_q;
	logic                  out_ok_q;
	logic signed [CW-1:0]  sk_x_q;
	logic signed [CW-1:0]  sk_y_q;
	logic                  sk_ok_q;
	logic                  out_take;
	logic                  pipe_out;

	assign out_take = out_vld_q && !out_stall;
	assign pipe_out = adv && vld_s[NST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			sk_full_q <= 1'b0;
		end else if (sk_full_q) begin
			if (out_take) begin
				sk_full_q <= 1'b0;
			end
		end else if (!out_vld_q || out_take) begin
			out_vld_q <= pipe_out;
		end else if (pipe_out) begin
			sk_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (sk_full_q) begin
			if (out_take) begin
				out_x_q  <= sk_x_q;
				out_y_q  <= sk_y_q;
				out_ok_q <= sk_ok_q;
			end
		end else if (!out_vld_q || out_take) begin
			out_x_q  <= ctx_s[NST].tgx;
			out_y_q  <= ctx_s[NST].tgy;
			out_ok_q <= ctx_s[NST].ok;
		end else if (pipe_out) begin
			sk_x_q  <= ctx_s[NST].tgx;
			sk_y_q  <= ctx_s[NST].tgy;
			sk_ok_q <= ctx_s[NST].ok;
		end
	end

	assign out_valid = out_vld_q;
	assign target_x  = out_x_q;
	assign target_y  = out_y_q;
	assign valid_res = out_ok_q;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	a_skid_needs_out : assert property (@(posedge clk) disable iff (!arst_n)
		sk_full_q |-> out_vld_q)
		else $error("skid holds a result while the output register is empty");

	a_skid_holds : assert property (@(posedge clk) disable iff (!arst_n)
		(sk_full_q && out_stall) |=> sk_full_q)
		else $error("skid emptied while the output was stalled");

	a_skid_fill : assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sk_full_q) |-> $past(out_vld_q && out_stall && vld_s[NST]))
		else $error("skid filled without a stalled result and a new one behind it");

endmodule
